// File: src/sgta_pkg.sv
// Shared types and constants for the generation tagged slot allocator.
// Used by sgta_exec and generation_tagged_slot_allocator; no dependencies.
package sgta_pkg;

   localparam int OPCODE_W    = 3;
   localparam int INDEX_W     = 16;
   localparam int REQ_GEN_W   = 32;
   localparam int CSUM_W      = 32;
   localparam int GRANT_W     = 10;
   localparam int COUNT_W     = 11;
   localparam int STATUS_W    = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam int REQ_DATA_W  = 80;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 96;
   localparam int RSP_USER_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AREA_ACTIVE = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC       = 3'd0,
      OP_FREE        = 3'd1,
      OP_WRITE_BEGIN = 3'd2,
      OP_WRITE_DONE  = 3'd3,
      OP_READ_BEGIN  = 3'd4,
      OP_READ_DONE   = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 4'd0,
      ST_INVALID  = 4'd1,
      ST_STALE    = 4'd2,
      ST_BUSY     = 4'd3,
      ST_NOSPACE  = 4'd4,
      ST_OVERFLOW = 4'd5,
      ST_IOERR    = 4'd6,
      ST_NODATA   = 4'd7,
      ST_MISMATCH = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      SS_FREE     = 2'd0,
      SS_RESERVED = 2'd1,
      SS_STORED   = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      S_CLEAR = 2'd0,
      S_IDLE  = 2'd1,
      S_EXEC  = 2'd2
   } state_type;

   typedef struct packed {
      status_type status;
      logic       entry_we;
      logic       head_pop;
      logic       head_push;
   } exec_ctl_type;

endpackage

// File: src/sgta_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sgta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sgta_exec.sv
// Per-transaction decision logic: checks one slot entry against the request and
// forms the new entry, the result fields and the free list control. Uses sgta_pkg.
module sgta_exec #(
   parameter int SLOTS    = 1024,
   parameter int GEN_BITS = 32
) (
   input  logic [sgta_pkg::OPCODE_W-1:0]  opcode,
   input  logic [sgta_pkg::INDEX_W-1:0]   slot_index,
   input  logic [sgta_pkg::REQ_GEN_W-1:0] slot_generation,
   input  logic                           io_ok,
   input  logic [sgta_pkg::CSUM_W-1:0]    page_checksum,
   input  logic                           area_active,
   input  logic [$clog2(SLOTS+1)-1:0]     slot_count,
   input  logic [$clog2(SLOTS+1)-1:0]     list_head,
   input  logic [$clog2(SLOTS+1)-1:0]     spare_count,
   input  logic [GEN_BITS-1:0]            e_gen,
   input  logic [1:0]                     e_state,
   input  logic [sgta_pkg::CSUM_W-1:0]    e_csum,
   input  logic                           e_busy,
   output sgta_pkg::exec_ctl_type         ctl,
   output logic [GEN_BITS-1:0]            w_gen,
   output logic [1:0]                     w_state,
   output logic [sgta_pkg::CSUM_W-1:0]    w_csum,
   output logic                           w_busy,
   output logic                           w_next_nil,
   output logic [sgta_pkg::GRANT_W-1:0]   granted_index,
   output logic [sgta_pkg::REQ_GEN_W-1:0] granted_generation,
   output logic [sgta_pkg::CSUM_W-1:0]    stored_checksum
);

   localparam int PTR_W = $clog2(SLOTS+1);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);
   localparam logic [GEN_BITS-1:0] GEN_MAX = {GEN_BITS{1'b1}};

   sgta_pkg::slot_state_type cur_state;
   sgta_pkg::status_type     look;

   assign cur_state = sgta_pkg::slot_state_type'(e_state);

   always_comb begin
      if (32'(slot_index) >= 32'(slot_count)) begin
         look = sgta_pkg::ST_INVALID;
      end else if (64'(e_gen) != 64'(slot_generation)) begin
         look = sgta_pkg::ST_STALE;
      end else if (cur_state == sgta_pkg::SS_FREE) begin
         look = sgta_pkg::ST_INVALID;
      end else begin
         look = sgta_pkg::ST_OK;
      end
   end

   always_comb begin
      ctl.status         = sgta_pkg::ST_OK;
      ctl.entry_we       = 1'b0;
      ctl.head_pop       = 1'b0;
      ctl.head_push      = 1'b0;
      w_gen              = e_gen;
      w_state            = e_state;
      w_csum             = e_csum;
      w_busy             = e_busy;
      w_next_nil         = 1'b0;
      granted_index      = '0;
      granted_generation = '0;
      stored_checksum    = '0;
      case (sgta_pkg::opcode_type'(opcode))
         sgta_pkg::OP_ALLOC: begin
            if (!area_active || spare_count == '0) begin
               ctl.status = sgta_pkg::ST_NOSPACE;
            end else if (list_head == NIL || list_head >= slot_count) begin
               ctl.status = sgta_pkg::ST_IOERR;
            end else if (e_gen == GEN_MAX) begin
               ctl.status = sgta_pkg::ST_OVERFLOW;
            end else if (cur_state != sgta_pkg::SS_FREE) begin
               ctl.status = sgta_pkg::ST_IOERR;
            end else begin
               ctl.entry_we       = 1'b1;
               ctl.head_pop       = 1'b1;
               w_gen              = e_gen + GEN_BITS'(1);
               w_state            = sgta_pkg::SS_RESERVED;
               w_csum             = '0;
               w_busy             = 1'b0;
               w_next_nil         = 1'b1;
               granted_index      = sgta_pkg::GRANT_W'(list_head);
               granted_generation = sgta_pkg::REQ_GEN_W'(e_gen + GEN_BITS'(1));
            end
         end
         sgta_pkg::OP_FREE: begin
            if (look != sgta_pkg::ST_OK) begin
               ctl.status = look;
            end else if (e_busy) begin
               ctl.status = sgta_pkg::ST_BUSY;
            end else begin
               ctl.entry_we  = 1'b1;
               ctl.head_push = 1'b1;
               w_state       = sgta_pkg::SS_FREE;
               w_csum        = '0;
            end
         end
         sgta_pkg::OP_WRITE_BEGIN: begin
            if (look != sgta_pkg::ST_OK) begin
               ctl.status = look;
            end else if (e_busy) begin
               ctl.status = sgta_pkg::ST_BUSY;
            end else begin
               ctl.entry_we = 1'b1;
               w_state      = sgta_pkg::SS_RESERVED;
               w_csum       = '0;
               w_busy       = 1'b1;
            end
         end
         sgta_pkg::OP_WRITE_DONE: begin
            if (look != sgta_pkg::ST_OK) begin
               ctl.status = look;
            end else if (!e_busy) begin
               ctl.status = sgta_pkg::ST_IOERR;
            end else begin
               ctl.entry_we = 1'b1;
               w_busy       = 1'b0;
               if (io_ok) begin
                  w_csum  = page_checksum;
                  w_state = sgta_pkg::SS_STORED;
               end else begin
                  ctl.status = sgta_pkg::ST_IOERR;
               end
            end
         end
         sgta_pkg::OP_READ_BEGIN: begin
            if (look != sgta_pkg::ST_OK) begin
               ctl.status = look;
            end else if (cur_state != sgta_pkg::SS_STORED) begin
               ctl.status = sgta_pkg::ST_NODATA;
            end else if (e_busy) begin
               ctl.status = sgta_pkg::ST_BUSY;
            end else begin
               ctl.entry_we    = 1'b1;
               w_busy          = 1'b1;
               stored_checksum = e_csum;
            end
         end
         sgta_pkg::OP_READ_DONE: begin
            if (look != sgta_pkg::ST_OK) begin
               ctl.status = look;
            end else if (!e_busy) begin
               ctl.status = sgta_pkg::ST_IOERR;
            end else begin
               ctl.entry_we = 1'b1;
               w_busy       = 1'b0;
               if (!io_ok) begin
                  ctl.status = sgta_pkg::ST_IOERR;
               end else if (page_checksum != e_csum) begin
                  ctl.status = sgta_pkg::ST_MISMATCH;
               end
            end
         end
         default: begin
            ctl.status = sgta_pkg::ST_INVALID;
         end
      endcase
   end

endmodule

// File: src/generation_tagged_slot_allocator.sv
// Top level of the generation tagged slot allocator: sequencer, slot table
// memory and result register. Uses sgta_pkg, sgta_ram and sgta_exec.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata, req_tuser
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Each transaction is accepted in S_IDLE, where the slot entry is read from the slot
// table RAM; in S_EXEC the entry is checked, written back and the result loaded.
// S_EXEC holds while the result register is still full; requests wait until S_IDLE.
// After reset and after each slot_count write the table is swept, one entry per
// cycle, over slot_count entries (SLOTS after reset); req_tready is low meanwhile.
// csr_ready is always high.
module generation_tagged_slot_allocator #(
   parameter int SLOTS    = 1024,
   parameter int GEN_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // slot_index[15:0], slot_generation[47:16], page_checksum[79:48]
   input  logic [sgta_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode[2:0], io_ok[3]
   input  logic [sgta_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // granted_index[9:0], granted_generation[41:10], expected_checksum[73:42],
   // free_count[84:74], used_count[95:85]
   output logic [sgta_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status[3:0]
   output logic [sgta_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgta_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sgta_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int PTR_W   = $clog2(SLOTS+1);
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int ENTRY_W = GEN_BITS + 2 + sgta_pkg::CSUM_W + 1 + PTR_W;
   localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

   sgta_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0] clr_ff;
   logic [PTR_W-1:0] slot_count_ff;
   logic             area_ff;
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] free_ff;
   logic [PTR_W-1:0] used_ff;

   logic [sgta_pkg::OPCODE_W-1:0]  op_ff;
   logic [sgta_pkg::INDEX_W-1:0]   idx_ff;
   logic [sgta_pkg::REQ_GEN_W-1:0] gen_ff;
   logic                           io_ok_ff;
   logic [sgta_pkg::CSUM_W-1:0]    csum_ff;
   logic [ADDR_W-1:0]              addr_ff;

   logic                           rsp_valid_ff;
   sgta_pkg::status_type           rsp_status_ff;
   logic [sgta_pkg::GRANT_W-1:0]   rsp_index_ff;
   logic [sgta_pkg::REQ_GEN_W-1:0] rsp_gen_ff;
   logic [sgta_pkg::CSUM_W-1:0]    rsp_csum_ff;
   logic [sgta_pkg::COUNT_W-1:0]   rsp_free_ff;
   logic [sgta_pkg::COUNT_W-1:0]   rsp_used_ff;

   logic req_fire, exec_go, csr_count_wr, csr_area_wr, clr_done;
   logic [31:0]      csr_clamp;
   logic [PTR_W-1:0] csr_count;
   logic [PTR_W-1:0] clr_next, clr_link;
   logic [PTR_W-1:0] head_in, free_in, used_in;

   logic [sgta_pkg::OPCODE_W-1:0]  req_opcode;
   logic [sgta_pkg::INDEX_W-1:0]   req_index;

   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic [GEN_BITS-1:0]         e_gen, w_gen;
   logic [1:0]                  e_state, w_state;
   logic [sgta_pkg::CSUM_W-1:0] e_csum, w_csum;
   logic                        e_busy, w_busy, w_next_nil;
   logic [PTR_W-1:0]            e_next, w_next;

   sgta_pkg::exec_ctl_type         ctl;
   logic [sgta_pkg::GRANT_W-1:0]   x_index;
   logic [sgta_pkg::REQ_GEN_W-1:0] x_gen;
   logic [sgta_pkg::CSUM_W-1:0]    x_csum;

   assign req_opcode = req_tuser[2:0];
   assign req_index  = req_tdata[15:0];

   assign csr_ready    = 1'b1;
   assign csr_count_wr = csr_valid && (csr_index == sgta_pkg::CSR_SLOT_COUNT);
   assign csr_area_wr  = csr_valid && (csr_index == sgta_pkg::CSR_AREA_ACTIVE);

   always_comb begin
      csr_clamp = 32'(csr_data);
      if (csr_clamp == 32'd0) begin
         csr_clamp = 32'd1;
      end else if (csr_clamp > 32'(SLOTS)) begin
         csr_clamp = 32'(SLOTS);
      end
      csr_count = PTR_W'(csr_clamp);
   end

   assign clr_next = clr_ff + PTR_W'(1);
   assign clr_link = (clr_next < slot_count_ff) ? clr_next : NIL;
   assign clr_done = (clr_next == slot_count_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgta_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      exec_go    = 1'b0;
      ram_re     = 1'b0;
      case (state_ff)
         sgta_pkg::S_CLEAR: begin
            if (clr_done) begin
               state_in = sgta_pkg::S_IDLE;
            end
         end
         sgta_pkg::S_IDLE: begin
            req_tready = 1'b1;
            ram_re     = req_tvalid;
            if (req_tvalid) begin
               state_in = sgta_pkg::S_EXEC;
            end
         end
         sgta_pkg::S_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               exec_go  = 1'b1;
               state_in = sgta_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sgta_pkg::S_CLEAR;
         end
      endcase
      if (csr_count_wr) begin
         state_in = sgta_pkg::S_CLEAR;
      end
   end

   assign req_fire = req_tvalid && req_tready;

   // slot table memory
   assign ram_raddr = (sgta_pkg::opcode_type'(req_opcode) == sgta_pkg::OP_ALLOC)
                      ? head_ff[ADDR_W-1:0] : req_index[ADDR_W-1:0];

   assign {e_gen, e_state, e_csum, e_busy, e_next} = ram_rdata;

   assign w_next = ctl.head_push ? head_ff : (w_next_nil ? NIL : e_next);

   always_comb begin
      if (state_ff == sgta_pkg::S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff[ADDR_W-1:0];
         ram_wdata = {{GEN_BITS{1'b0}}, sgta_pkg::SS_FREE, {sgta_pkg::CSUM_W{1'b0}},
                      1'b0, clr_link};
      end else begin
         ram_we    = exec_go && ctl.entry_we;
         ram_waddr = addr_ff;
         ram_wdata = {w_gen, w_state, w_csum, w_busy, w_next};
      end
   end

   sgta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sgta_exec #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS)
   ) u_exec (
      .opcode             (op_ff),
      .slot_index         (idx_ff),
      .slot_generation    (gen_ff),
      .io_ok              (io_ok_ff),
      .page_checksum      (csum_ff),
      .area_active        (area_ff),
      .slot_count         (slot_count_ff),
      .list_head          (head_ff),
      .spare_count        (free_ff),
      .e_gen              (e_gen),
      .e_state            (e_state),
      .e_csum             (e_csum),
      .e_busy             (e_busy),
      .ctl                (ctl),
      .w_gen              (w_gen),
      .w_state            (w_state),
      .w_csum             (w_csum),
      .w_busy             (w_busy),
      .w_next_nil         (w_next_nil),
      .granted_index      (x_index),
      .granted_generation (x_gen),
      .stored_checksum    (x_csum)
   );

   // free list head and counts
   always_comb begin
      head_in = head_ff;
      free_in = free_ff;
      used_in = used_ff;
      if (ctl.head_pop) begin
         head_in = e_next;
         free_in = free_ff - PTR_W'(1);
         used_in = used_ff + PTR_W'(1);
      end else if (ctl.head_push) begin
         head_in = PTR_W'(idx_ff);
         free_in = free_ff + PTR_W'(1);
         used_in = used_ff - PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         slot_count_ff <= PTR_W'(SLOTS);
         area_ff       <= 1'b1;
         head_ff       <= '0;
         free_ff       <= PTR_W'(SLOTS);
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (state_ff == sgta_pkg::S_CLEAR) begin
            clr_ff <= clr_next;
         end
         if (exec_go) begin
            head_ff      <= head_in;
            free_ff      <= free_in;
            used_ff      <= used_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_area_wr) begin
            area_ff <= csr_data[0];
         end
         if (csr_count_wr) begin
            slot_count_ff <= csr_count;
            clr_ff        <= '0;
            head_ff       <= '0;
            free_ff       <= csr_count;
            used_ff       <= '0;
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_opcode;
         idx_ff   <= req_index;
         gen_ff   <= req_tdata[47:16];
         io_ok_ff <= req_tuser[3];
         csum_ff  <= req_tdata[79:48];
         addr_ff  <= ram_raddr;
      end
      if (exec_go) begin
         rsp_status_ff <= ctl.status;
         rsp_index_ff  <= x_index;
         rsp_gen_ff    <= x_gen;
         rsp_csum_ff   <= x_csum;
         rsp_free_ff   <= sgta_pkg::COUNT_W'(free_in);
         rsp_used_ff   <= sgta_pkg::COUNT_W'(used_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_used_ff, rsp_free_ff, rsp_csum_ff, rsp_gen_ff, rsp_index_ff};

   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      ((PTR_W+1)'(free_ff) + (PTR_W+1)'(used_ff)) == (PTR_W+1)'(slot_count_ff))
      else $error("free and used counts do not add up to slot_count");

   a_head_nil: assert property (@(posedge clock) disable iff (reset)
      (free_ff == '0) == (head_ff == NIL))
      else $error("free list head disagrees with free count");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_re)
      else $error("slot table read issued during write back");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (exec_go && ctl.head_pop && !csr_count_wr) |=> free_ff == $past(free_ff) - PTR_W'(1))
      else $error("allocate did not take one free slot");

endmodule

// File: verif/tb_generation_tagged_slot_allocator.sv
// Self-checking testbench for generation_tagged_slot_allocator: a directed table, then
// random slot lifecycles over several table sizes, checked against a local slot table model.
// Depends on sgta_pkg and the RTL under src/.
module tb_generation_tagged_slot_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 1024;
   localparam logic [10:0] NIL = 11'd1024;
   localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int LIMIT_NS = 5_000_000;
   localparam int PHASES = 7;

   typedef struct {
      sgta_pkg::status_type status;
      logic [9:0]           grant_idx;
      logic [31:0]          grant_gen;
      logic [31:0]          stored_sum;
      logic [10:0]          free_cnt;
      logic [10:0]          used_cnt;
   } reply_type;

   typedef struct {
      logic [2:0]  opcode;
      logic [15:0] idx;
      logic [31:0] gen;
      logic        io_ok;
      logic [31:0] csum;
   } slot_op_type;

   typedef struct {
      slot_op_type op;
      bit          fixed;
      reply_type   reply;
   } table_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [sgta_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic [sgta_pkg::REQ_USER_W-1:0]  req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [sgta_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [sgta_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [sgta_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sgta_pkg::CSR_DATA_W-1:0]  csr_data;

   // slot table model
   logic [31:0]              gen_tbl [SLOTS];
   sgta_pkg::slot_state_type state_tbl [SLOTS];
   logic [31:0]              sum_tbl [SLOTS];
   bit                       busy_tbl [SLOTS];
   logic [10:0]              link_tbl [SLOTS];
   bit                       read_open [SLOTS];
   logic [10:0]              head_ptr;
   logic [10:0]              free_total;
   logic [10:0]              used_total;
   logic [10:0]              live_limit;
   bit                       area_on;

   reply_type     awaited_replies [$];
   table_row_type dir_rows [$];
   int            mismatch_count = 0;
   bit            req_burst = 1'b0;

   bit          phase_rebuild [PHASES] = '{1, 1, 1, 0, 1, 1, 1};
   logic [10:0] phase_count [PHASES]   = '{11'd0, 11'd2047, 11'd8, 11'd0, 11'd1024, 11'd1,
                                           11'd24};
   bit          phase_active [PHASES]  = '{1, 0, 1, 0, 1, 1, 1};
   int          phase_items [PHASES]   = '{40, 30, 220, 60, 120, 40, 290};

   generation_tagged_slot_allocator #(.SLOTS(SLOTS), .GEN_BITS(32)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void rebuild_slots();
      for (int i = 0; i < SLOTS; i++) begin
         gen_tbl[i] = '0;
         state_tbl[i] = sgta_pkg::SS_FREE;
         sum_tbl[i] = '0;
         busy_tbl[i] = 1'b0;
         read_open[i] = 1'b0;
         link_tbl[i] = (i + 1 < live_limit) ? 11'(i + 1) : NIL;
      end
      head_ptr = '0;
      free_total = live_limit;
      used_total = '0;
   endfunction

   function automatic reply_type apply_slot_op(slot_op_type op);
      reply_type   r;
      logic [10:0] h;
      logic [9:0]  s;
      r.status = sgta_pkg::ST_OK;
      r.grant_idx = '0;
      r.grant_gen = '0;
      r.stored_sum = '0;
      h = head_ptr;
      s = op.idx[9:0];
      case (op.opcode)
         sgta_pkg::OP_ALLOC: begin
            if (!area_on || free_total == 0) r.status = sgta_pkg::ST_NOSPACE;
            else if (h == NIL || h >= live_limit) r.status = sgta_pkg::ST_IOERR;
            else if (gen_tbl[h[9:0]] == GEN_MAX) r.status = sgta_pkg::ST_OVERFLOW;
            else if (state_tbl[h[9:0]] != sgta_pkg::SS_FREE) r.status = sgta_pkg::ST_IOERR;
            else begin
               head_ptr = link_tbl[h[9:0]];
               link_tbl[h[9:0]] = NIL;
               gen_tbl[h[9:0]] = gen_tbl[h[9:0]] + 32'd1;
               sum_tbl[h[9:0]] = '0;
               state_tbl[h[9:0]] = sgta_pkg::SS_RESERVED;
               busy_tbl[h[9:0]] = 1'b0;
               free_total--;
               used_total++;
               r.grant_idx = h[9:0];
               r.grant_gen = gen_tbl[h[9:0]];
            end
         end
         sgta_pkg::OP_FREE, sgta_pkg::OP_WRITE_BEGIN, sgta_pkg::OP_WRITE_DONE,
         sgta_pkg::OP_READ_BEGIN, sgta_pkg::OP_READ_DONE: begin
            if (op.idx >= live_limit) r.status = sgta_pkg::ST_INVALID;
            else if (gen_tbl[s] != op.gen) r.status = sgta_pkg::ST_STALE;
            else if (state_tbl[s] == sgta_pkg::SS_FREE) r.status = sgta_pkg::ST_INVALID;
            else begin
               case (op.opcode)
                  sgta_pkg::OP_FREE: begin
                     if (busy_tbl[s]) r.status = sgta_pkg::ST_BUSY;
                     else begin
                        state_tbl[s] = sgta_pkg::SS_FREE;
                        sum_tbl[s] = '0;
                        link_tbl[s] = head_ptr;
                        head_ptr = {1'b0, s};
                        free_total++;
                        used_total--;
                     end
                  end
                  sgta_pkg::OP_WRITE_BEGIN: begin
                     if (busy_tbl[s]) r.status = sgta_pkg::ST_BUSY;
                     else begin
                        state_tbl[s] = sgta_pkg::SS_RESERVED;
                        sum_tbl[s] = '0;
                        busy_tbl[s] = 1'b1;
                     end
                  end
                  sgta_pkg::OP_WRITE_DONE: begin
                     if (!busy_tbl[s]) r.status = sgta_pkg::ST_IOERR;
                     else begin
                        busy_tbl[s] = 1'b0;
                        if (op.io_ok) begin
                           sum_tbl[s] = op.csum;
                           state_tbl[s] = sgta_pkg::SS_STORED;
                        end else r.status = sgta_pkg::ST_IOERR;
                     end
                  end
                  sgta_pkg::OP_READ_BEGIN: begin
                     if (state_tbl[s] != sgta_pkg::SS_STORED) r.status = sgta_pkg::ST_NODATA;
                     else if (busy_tbl[s]) r.status = sgta_pkg::ST_BUSY;
                     else begin
                        r.stored_sum = sum_tbl[s];
                        busy_tbl[s] = 1'b1;
                     end
                  end
                  default: begin
                     if (!busy_tbl[s]) r.status = sgta_pkg::ST_IOERR;
                     else begin
                        busy_tbl[s] = 1'b0;
                        if (!op.io_ok) r.status = sgta_pkg::ST_IOERR;
                        else if (op.csum != sum_tbl[s]) r.status = sgta_pkg::ST_MISMATCH;
                     end
                  end
               endcase
            end
         end
         default: r.status = sgta_pkg::ST_INVALID;
      endcase
      r.free_cnt = free_total;
      r.used_cnt = used_total;
      return r;
   endfunction

   function automatic slot_op_type make_random_op();
      slot_op_type op;
      int          live_cnt;
      int          live;
      int          k;
      int          roll;
      int          pick;
      op.opcode = sgta_pkg::OP_ALLOC;
      op.idx = 16'($urandom_range(0, 65535));
      op.gen = $urandom();
      op.io_ok = 1'($urandom_range(0, 1));
      op.csum = $urandom();
      live_cnt = 0;
      live = -1;
      for (int i = 0; i < live_limit; i++) if (state_tbl[i] != sgta_pkg::SS_FREE) live_cnt++;
      if (live_cnt > 0) begin
         k = $urandom_range(0, live_cnt - 1);
         for (int i = 0; i < live_limit && live < 0; i++) begin
            if (state_tbl[i] != sgta_pkg::SS_FREE) begin
               if (k == 0) live = i;
               k--;
            end
         end
      end
      roll = $urandom_range(0, 99);
      if (roll < 22 || (live < 0 && roll < 85)) begin
         op.opcode = sgta_pkg::OP_ALLOC;
      end else if (roll < 85) begin
         op.idx = 16'(live);
         op.gen = gen_tbl[live];
         op.io_ok = ($urandom_range(0, 9) != 0);
         pick = $urandom_range(0, 19);
         if (busy_tbl[live]) begin
            if (pick < 14) begin
               op.opcode = read_open[live] ? sgta_pkg::OP_READ_DONE : sgta_pkg::OP_WRITE_DONE;
            end else if (pick < 16) begin
               op.opcode = read_open[live] ? sgta_pkg::OP_WRITE_DONE : sgta_pkg::OP_READ_DONE;
            end else if (pick == 16) op.opcode = sgta_pkg::OP_FREE;
            else if (pick == 17) op.opcode = sgta_pkg::OP_WRITE_BEGIN;
            else op.opcode = sgta_pkg::OP_READ_BEGIN;
         end else begin
            if (pick < 7) op.opcode = sgta_pkg::OP_WRITE_BEGIN;
            else if (pick < 13) op.opcode = sgta_pkg::OP_READ_BEGIN;
            else if (pick < 17) op.opcode = sgta_pkg::OP_FREE;
            else if (pick < 19) op.opcode = sgta_pkg::OP_WRITE_DONE;
            else op.opcode = sgta_pkg::OP_READ_DONE;
         end
         if (op.opcode == sgta_pkg::OP_READ_DONE && $urandom_range(0, 4) != 0) begin
            op.csum = sum_tbl[live];
         end
      end else begin
         op.opcode = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 1) != 0) op.idx = 16'($urandom_range(0, live_limit));
         case ($urandom_range(0, 3))
            0: op.gen = gen_tbl[op.idx[9:0]];
            1: op.gen = gen_tbl[op.idx[9:0]] + 32'd1;
            2: op.gen = gen_tbl[op.idx[9:0]] - 32'd1;
            default: ;
         endcase
      end
      return op;
   endfunction

   task automatic add_row(logic [2:0] opc, logic [15:0] idx, logic [31:0] gen, logic io,
                          logic [31:0] csum, bit fixed, sgta_pkg::status_type st,
                          logic [31:0] gg, logic [31:0] es, logic [10:0] fc,
                          logic [10:0] uc);
      table_row_type row;
      row.op.opcode = opc;
      row.op.idx = idx;
      row.op.gen = gen;
      row.op.io_ok = io;
      row.op.csum = csum;
      row.fixed = fixed;
      row.reply.status = st;
      row.reply.grant_idx = '0;
      row.reply.grant_gen = gg;
      row.reply.stored_sum = es;
      row.reply.free_cnt = fc;
      row.reply.used_cnt = uc;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   task automatic send_op(slot_op_type op, bit fixed, reply_type fixed_reply);
      reply_type r;
      int        gap;
      if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {op.csum, op.gen, op.idx};
      req_tuser <= {op.io_ok, op.opcode};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      r = apply_slot_op(op);
      if (op.opcode == sgta_pkg::OP_READ_BEGIN && r.status == sgta_pkg::ST_OK) begin
         read_open[op.idx[9:0]] = 1'b1;
      end
      if (op.opcode == sgta_pkg::OP_WRITE_BEGIN && r.status == sgta_pkg::ST_OK) begin
         read_open[op.idx[9:0]] = 1'b0;
      end
      if (fixed) awaited_replies.insert(awaited_replies.size(), fixed_reply);
      else awaited_replies.insert(awaited_replies.size(), r);
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(logic [sgta_pkg::CSR_INDEX_W-1:0] index,
                            logic [sgta_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (index == sgta_pkg::CSR_SLOT_COUNT) begin
         live_limit = (data == 0) ? 11'd1 : (data > SLOTS) ? 11'(SLOTS) : data;
         rebuild_slots();
      end else begin
         area_on = data[0];
      end
   endtask

   initial begin : stimulus
      reply_type blank;
      blank = '{sgta_pkg::ST_OK, '0, '0, '0, '0, '0};
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = sgta_pkg::CSR_SLOT_COUNT;
      csr_data = '0;
      live_limit = 11'(SLOTS);
      area_on = 1'b1;
      rebuild_slots();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_row(OP_SPARE_A, 16'd0, 32'd0, 1'b0, 32'd0, 1, sgta_pkg::ST_INVALID, 0, 0, 11'd1024,
              11'd0);
      add_row(OP_SPARE_B, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1,
              sgta_pkg::ST_INVALID, 0, 0, 11'd1024, 11'd0);
      add_row(sgta_pkg::OP_FREE, 16'd0, 32'd0, 1'b1, 32'd0, 1, sgta_pkg::ST_INVALID, 0, 0,
              11'd1024, 11'd0);
      add_row(sgta_pkg::OP_WRITE_BEGIN, 16'd1024, 32'd0, 1'b0, 32'd0, 1,
              sgta_pkg::ST_INVALID, 0, 0, 11'd1024, 11'd0);
      add_row(sgta_pkg::OP_READ_BEGIN, 16'hFFFF, 32'd0, 1'b0, 32'd0, 1,
              sgta_pkg::ST_INVALID, 0, 0, 11'd1024, 11'd0);
      add_row(sgta_pkg::OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1,
              sgta_pkg::ST_OK, 32'd1, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_WRITE_BEGIN, 16'd0, 32'd0, 1'b1, 32'd0, 1, sgta_pkg::ST_STALE,
              0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_WRITE_DONE, 16'd0, 32'd1, 1'b1, 32'h1234_5678, 1,
              sgta_pkg::ST_IOERR, 0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_READ_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 1, sgta_pkg::ST_NODATA,
              0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_WRITE_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 1, sgta_pkg::ST_OK,
              0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_WRITE_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 1, sgta_pkg::ST_BUSY,
              0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_FREE, 16'd0, 32'd1, 1'b0, 32'd0, 1, sgta_pkg::ST_BUSY,
              0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_WRITE_DONE, 16'd0, 32'd1, 1'b1, 32'hFFFF_FFFF, 1,
              sgta_pkg::ST_OK, 0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_READ_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 1, sgta_pkg::ST_OK,
              0, 32'hFFFF_FFFF, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_READ_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 1, sgta_pkg::ST_BUSY,
              0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_READ_DONE, 16'd0, 32'd1, 1'b1, 32'd0, 1, sgta_pkg::ST_MISMATCH,
              0, 0, 11'd1023, 11'd1);
      add_row(sgta_pkg::OP_READ_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 0, sgta_pkg::ST_OK,
              0, 0, 0, 0);
      add_row(sgta_pkg::OP_READ_DONE, 16'd0, 32'd1, 1'b1, 32'hFFFF_FFFF, 0,
              sgta_pkg::ST_OK, 0, 0, 0, 0);
      add_row(sgta_pkg::OP_READ_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 0, sgta_pkg::ST_OK,
              0, 0, 0, 0);
      add_row(sgta_pkg::OP_READ_DONE, 16'd0, 32'd1, 1'b0, 32'hFFFF_FFFF, 0,
              sgta_pkg::ST_OK, 0, 0, 0, 0);
      add_row(sgta_pkg::OP_WRITE_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 0, sgta_pkg::ST_OK,
              0, 0, 0, 0);
      add_row(sgta_pkg::OP_READ_DONE, 16'd0, 32'd1, 1'b1, 32'd0, 0, sgta_pkg::ST_OK,
              0, 0, 0, 0);
      add_row(sgta_pkg::OP_WRITE_BEGIN, 16'd0, 32'd1, 1'b0, 32'd0, 0, sgta_pkg::ST_OK,
              0, 0, 0, 0);
      add_row(sgta_pkg::OP_WRITE_DONE, 16'd0, 32'd1, 1'b0, 32'hFFFF_FFFF, 0,
              sgta_pkg::ST_OK, 0, 0, 0, 0);
      add_row(sgta_pkg::OP_FREE, 16'd0, 32'd1, 1'b0, 32'd0, 1, sgta_pkg::ST_OK,
              0, 0, 11'd1024, 11'd0);
      add_row(sgta_pkg::OP_ALLOC, 16'd0, 32'd0, 1'b0, 32'd0, 0, sgta_pkg::ST_OK,
              0, 0, 0, 0);
      add_row(sgta_pkg::OP_FREE, 16'd0, 32'd1, 1'b0, 32'd0, 0, sgta_pkg::ST_OK,
              0, 0, 0, 0);

      foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].reply);

      for (int p = 0; p < PHASES; p++) begin
         drain_replies();
         if (phase_rebuild[p]) write_csr(sgta_pkg::CSR_SLOT_COUNT, phase_count[p]);
         write_csr(sgta_pkg::CSR_AREA_ACTIVE, {10'($urandom()), phase_active[p]});
         csr_valid <= 1'b0;
         repeat (phase_items[p]) send_op(make_random_op(), 0, blank);
      end

      drain_replies();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin : reply_sink
      int stall;
      bit sink_burst;
      rsp_tready = 1'b0;
      sink_burst = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
         stall = sink_burst ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin : reply_check
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            $display("%0t: result transaction with nothing pending, status %0d", $time,
                     rsp_tuser[3:0]);
            mismatch_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_tuser[3:0] !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tuser[3:0]);
               mismatch_count++;
            end
            if (rsp_tdata[9:0] !== want.grant_idx) begin
               $display("%0t: granted_index expected %0d actual %0d", $time, want.grant_idx,
                        rsp_tdata[9:0]);
               mismatch_count++;
            end
            if (rsp_tdata[41:10] !== want.grant_gen) begin
               $display("%0t: granted_generation expected %0h actual %0h", $time,
                        want.grant_gen, rsp_tdata[41:10]);
               mismatch_count++;
            end
            if (rsp_tdata[73:42] !== want.stored_sum) begin
               $display("%0t: stored checksum expected %0h actual %0h", $time,
                        want.stored_sum, rsp_tdata[73:42]);
               mismatch_count++;
            end
            if (rsp_tdata[84:74] !== want.free_cnt) begin
               $display("%0t: free_count expected %0d actual %0d", $time, want.free_cnt,
                        rsp_tdata[84:74]);
               mismatch_count++;
            end
            if (rsp_tdata[95:85] !== want.used_cnt) begin
               $display("%0t: used_count expected %0d actual %0d", $time, want.used_cnt,
                        rsp_tdata[95:85]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #LIMIT_NS;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: generation_tagged_slot_allocator.f
src/sgta_pkg.sv
src/sgta_ram.sv
src/sgta_exec.sv
src/generation_tagged_slot_allocator.sv
verif/tb_generation_tagged_slot_allocator.sv
